[rtl/hsbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsbt_pkg
// Types and constants for the bucketed hash set.
// ----------------------------------------------------------------------------
package hsbt_pkg;

    localparam int KEY_W            = 20;
    localparam int BUCKET_COUNT     = 1021;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int BKT_W            = $clog2(BUCKET_COUNT);

    // key / BUCKET_COUNT by reciprocal; the estimate is the quotient or one above
    localparam int RECIP_SHIFT = KEY_W + BKT_W;
    localparam longint RECIP   = (64'd1 << RECIP_SHIFT) / BUCKET_COUNT + 1;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = KEY_W + RECIP_W;
    localparam int Q_W         = KEY_W - BKT_W + 1;
    localparam int DIFF_W      = KEY_W + 2;

    typedef enum logic [1:0] {
        KIND_ADD      = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_CONTAINS = 2'd2
    } kind_t;

    typedef struct packed {
        logic [SLOTS_PER_BUCKET-1:0]            valid;
        logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0] keys;
    } row_t;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_QUOT  = 6'b000100,
        S_REM   = 6'b001000,
        S_READ  = 6'b010000,
        S_LOOK  = 6'b100000
    } state_t;

endpackage

[rtl/hash_set_bucketed_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_set_bucketed_table
// Hash set of 20-bit keys: add, remove or contains, one word in, one word out.
//
// Input channel in_valid/in_ready carries kind and key. Output channel
// out_valid/out_ready carries found (key present before the operation) and
// bucket_full (add refused, every slot of the bucket occupied).
// The bucket is key mod BUCKET_COUNT; each bucket is one row of a
// single-port table holding SLOTS_PER_BUCKET keys and their valid bits.
// One request is processed at a time: quotient, remainder, row read, then
// compare and write-back. The result is registered at write-back, and the
// next input word is taken only once the state has returned to idle, so the
// pace is set by the row read-modify-write sequence.
// After reset the table is swept, one row per cycle, over all BUCKET_COUNT
// (1021) rows with in_ready low; the set then starts empty.
// If the receiver stalls, the result holds in its output register and the
// next request waits at the write-back step until the register frees.
// ----------------------------------------------------------------------------
module hash_set_bucketed_table
    import hsbt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       kind,
    input  logic [KEY_W-1:0] key,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             found,
    output logic             bucket_full
);

    row_t mem [BUCKET_COUNT];

    state_t                 state_reg, state_next;
    logic [BKT_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [1:0]             kind_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [Q_W-1:0]         q_reg, q_next;
    logic [BKT_W-1:0]       bucket_reg, bucket_next;
    row_t                   rd_row_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg, found_next;
    logic                   full_reg, full_next;

    logic [PROD_W-1:0]           prod;
    logic signed [DIFF_W-1:0]    diff;
    logic [SLOTS_PER_BUCKET-1:0] hit_vec, free_vec, hit_first, free_first;
    row_t                        new_row, wr_row;
    logic                        wr_en;
    logic [BKT_W-1:0]            wr_addr;
    logic                        done;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign bucket_full = full_reg;

    assign done = (state_reg == S_LOOK) && (!out_valid_reg || out_ready);

    always_comb
    begin
        prod   = PROD_W'(key_reg) * PROD_W'(RECIP);
        q_next = prod[RECIP_SHIFT +: Q_W];
        diff   = $signed(DIFF_W'(key_reg)) - $signed(DIFF_W'(q_reg) * DIFF_W'(BUCKET_COUNT));
        if (diff[DIFF_W-1])
            diff = diff + $signed(DIFF_W'(BUCKET_COUNT));
        bucket_next = diff[BKT_W-1:0];
    end

    always_comb
    begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            hit_vec[s]  = rd_row_reg.valid[s] && (rd_row_reg.keys[s] == key_reg);
            free_vec[s] = !rd_row_reg.valid[s];
        end
        hit_first  = hit_vec & (~hit_vec + SLOTS_PER_BUCKET'(1));
        free_first = free_vec & (~free_vec + SLOTS_PER_BUCKET'(1));
        new_row    = rd_row_reg;
        full_next  = 1'b0;
        case (kind_reg)
            KIND_ADD:
            begin
                if (hit_vec == '0)
                begin
                    if (free_vec == '0)
                        full_next = 1'b1;
                    for (int s = 0; s < SLOTS_PER_BUCKET; s++)
                    begin
                        if (free_first[s])
                        begin
                            new_row.valid[s] = 1'b1;
                            new_row.keys[s]  = key_reg;
                        end
                    end
                end
            end
            KIND_REMOVE:
                new_row.valid = rd_row_reg.valid & ~hit_first;
            default:
                new_row = rd_row_reg;
        endcase
        found_next = (hit_vec != '0);
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = bucket_reg;
        wr_row  = new_row;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_row  = '0;
        end
        else if (done)
            wr_en = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + BKT_W'(1);
                if (clr_cnt_reg == BKT_W'(BUCKET_COUNT - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (in_valid)
                    state_next = S_QUOT;
            S_QUOT:  state_next = S_REM;
            S_REM:   state_next = S_READ;
            S_READ:  state_next = S_LOOK;
            S_LOOK:
                if (done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            key_reg  <= key;
        end
        if (state_reg == S_QUOT)
            q_reg <= q_next;
        if (state_reg == S_REM)
            bucket_reg <= bucket_next;
        if (state_reg == S_READ)
            rd_row_reg <= mem[bucket_reg];
        if (done)
        begin
            found_reg <= found_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_row;
    end

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bucket_full |-> !found)
        else $error("bucket_full with found set");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ready)
        else $error("input taken during clearing sweep");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> bucket_reg < BKT_W'(BUCKET_COUNT))
        else $error("bucket index out of range");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("second request taken while one in flight");

endmodule

[bench/hash_set_bucketed_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_set_bucketed_table_tb
// Self-checking bench for the bucketed hash set.
//
// A mirror of the set in the scoreboard predicts found and bucket_full for
// every word taken in; results are checked in order as they leave. Directed
// words cover empty, duplicate, absent, full-bucket and unused-kind cases;
// random words then hammer a few buckets so that they fill and drain, mixed
// with keys drawn over the full 20-bit range. Both sides idle at random.
// ----------------------------------------------------------------------------
module hash_set_bucketed_table_tb;
    import hsbt_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         TOTAL_SLOTS = BUCKET_COUNT * SLOTS_PER_BUCKET;
    localparam int         RAND_WORDS  = 450;

    class key_set_model;
        bit [KEY_W-1:0] slot_key  [TOTAL_SLOTS];
        bit             slot_used [TOTAL_SLOTS];
        bit [1:0]       answers   [$];
        int             mismatches;

        function void note_request(logic [1:0] k, logic [KEY_W-1:0] kv);
            int base;
            int hit;
            int free_slot;
            bit refused;
            bit [1:0] answer;
            base      = int'(kv % BUCKET_COUNT) * SLOTS_PER_BUCKET;
            hit       = -1;
            free_slot = -1;
            refused   = 1'b0;
            for (int s = 0; s < SLOTS_PER_BUCKET; s++)
            begin
                if (slot_used[base + s])
                begin
                    if (hit < 0 && slot_key[base + s] == kv)
                        hit = s;
                end
                else if (free_slot < 0)
                    free_slot = s;
            end
            case (kind_t'(k))
                KIND_ADD:
                begin
                    if (hit < 0)
                    begin
                        if (free_slot >= 0)
                        begin
                            slot_key[base + free_slot]  = kv;
                            slot_used[base + free_slot] = 1'b1;
                        end
                        else
                            refused = 1'b1;
                    end
                end
                KIND_REMOVE:
                begin
                    if (hit >= 0)
                        slot_used[base + hit] = 1'b0;
                end
                default: ;
            endcase
            answer = {hit >= 0, refused};
            answers.insert(answers.size(), answer);
        endfunction

        function void check_result(logic f, logic bf);
            bit [1:0] want;
            if (answers.size() == 0)
            begin
                $display("%0t: result with none outstanding: found=%b bucket_full=%b",
                         $time, f, bf);
                mismatches++;
                return;
            end
            want = answers.pop_front();
            if (f !== want[1])
            begin
                $display("%0t: found mismatch: expected %b actual %b", $time, want[1], f);
                mismatches++;
            end
            if (bf !== want[0])
            begin
                $display("%0t: bucket_full mismatch: expected %b actual %b",
                         $time, want[0], bf);
                mismatches++;
            end
        endfunction

        function int pending();
            return answers.size();
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [1:0]       kind      = KIND_CONTAINS;
    logic [KEY_W-1:0] key       = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             found;
    logic             bucket_full;

    key_set_model sb;
    int           burst_left = 0;
    int           stall_mode = 0;
    int           stall_left = 0;
    int           hot_bucket [4];

    hash_set_bucketed_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .bucket_full (bucket_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: stall pattern is redrawn at random times
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (stall_left[3:0] >= 4'd10);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(kind, key);
            if (out_valid && out_ready)
                sb.check_result(found, bucket_full);
        end
    end

    task automatic send_word(input logic [1:0] k, input logic [KEY_W-1:0] kv);
        int gap;
        in_valid <= 1'b1;
        kind     <= k;
        key      <= kv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // wait on the clock first so that the last word taken is already noted
    task automatic drain_results();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int               pick;
        logic [1:0]       k;
        logic [KEY_W-1:0] kv;

        sb = new();
        for (int i = 0; i < 4; i++)
            hot_bucket[i] = $urandom_range(0, BUCKET_COUNT - 1);
        hot_bucket[0] = 0;
        hot_bucket[3] = BUCKET_COUNT - 1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty set, duplicates, absent removes, extreme keys
        send_word(KIND_CONTAINS, 20'd0);
        send_word(KIND_ADD,      20'd0);
        send_word(KIND_ADD,      20'd0);
        send_word(KIND_CONTAINS, 20'd0);
        send_word(KIND_REMOVE,   20'd0);
        send_word(KIND_REMOVE,   20'd0);
        send_word(KIND_ADD,      20'hFFFFF);
        send_word(KIND_UNUSED,   20'hFFFFF);
        send_word(KIND_ADD,      20'd1000000);
        send_word(KIND_CONTAINS, 20'd1000000);
        // fill one bucket, then overflow it
        for (int m = 0; m < SLOTS_PER_BUCKET; m++)
            send_word(KIND_ADD, 20'(5 + m * BUCKET_COUNT));
        send_word(KIND_ADD,      20'(5 + SLOTS_PER_BUCKET * BUCKET_COUNT));
        send_word(KIND_ADD,      20'(5 + BUCKET_COUNT));
        send_word(KIND_CONTAINS, 20'(5 + SLOTS_PER_BUCKET * BUCKET_COUNT));
        send_word(KIND_REMOVE,   20'(5 + 2 * BUCKET_COUNT));
        send_word(KIND_ADD,      20'(5 + SLOTS_PER_BUCKET * BUCKET_COUNT));
        send_word(KIND_CONTAINS, 20'(5 + 2 * BUCKET_COUNT));
        send_word(KIND_REMOVE,   20'hFFFFF);
        send_word(KIND_UNUSED,   20'd0);
        send_word(KIND_ADD,      20'(BUCKET_COUNT - 1));
        send_word(KIND_CONTAINS, 20'(BUCKET_COUNT - 1));

        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if (n == RAND_WORDS / 2)
            begin
                in_valid <= 1'b0;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                k = KIND_ADD;
            else if (pick < 75)
                k = KIND_REMOVE;
            else if (pick < 95)
                k = KIND_CONTAINS;
            else
                k = KIND_UNUSED;
            // hot buckets hold eight candidate keys for four slots
            if ($urandom_range(0, 9) < 7)
                kv = 20'(hot_bucket[$urandom_range(0, 3)] + $urandom_range(0, 7) * BUCKET_COUNT);
            else
                kv = 20'($urandom_range(0, 20'hFFFFF));
            send_word(k, kv);
        end

        in_valid <= 1'b0;
        drain_results();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
